// ----- rtl/h74e_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h74e_pkg
// Types, constants and the nibble coder shared by the Hamming(7,4) byte
// stream encoder.
// ----------------------------------------------------------------------------
package h74e_pkg;

    localparam int ByteW  = 8;
    localparam int WordW  = 7;
    localparam int CodeW  = 2 * WordW;      // coded bits per input byte
    localparam int LeftW  = 6;              // most bits left over after a byte
    localparam int BufW   = LeftW + CodeW;  // bit buffer in the back end
    localparam int CntW   = 5;              // holds 0..BufW
    localparam int QDepth = 4;
    localparam int QPtrW  = 2;
    localparam int QCntW  = 3;

    // input transaction
    typedef struct packed {
        logic [ByteW-1:0] data_byte;
        logic             last_byte;
    } in_t;

    // result transaction
    typedef struct packed {
        logic [ByteW-1:0] code_byte;
        logic             end_of_message;
    } out_t;

    // one queued item: both code words and the end-of-message flag
    typedef struct packed {
        logic [CodeW-1:0] code;
        logic             last;
    } q_entry_t;

    // queue port: an entry and its valid bit
    typedef struct packed {
        logic     valid;
        q_entry_t entry;
    } q_xfer_t;

    // code bits in stream order: p1 p2 d3 p4 d2 d1 d0
    function automatic logic [WordW-1:0] code_nibble(input logic [3:0] n);
        logic p1;
        logic p2;
        logic p4;
        p1 = n[3] ^ n[2] ^ n[0];
        p2 = n[3] ^ n[1] ^ n[0];
        p4 = n[2] ^ n[1] ^ n[0];
        return {p1, p2, n[3], p4, n[2], n[1], n[0]};
    endfunction

endpackage
`default_nettype wire

// ----- rtl/h74e_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h74e_front
// Accepts input transactions, codes both nibbles and pushes the code words
// with the end-of-message flag into the queue.
// ----------------------------------------------------------------------------
module h74e_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire h74e_pkg::in_t    s_data,
    input  wire logic             q_full,
    output h74e_pkg::q_xfer_t     q_push
);

    logic unused_clk;

    // accept whenever the queue has room
    assign s_ready = ~q_full;

    // high nibble goes first in the stream
    always_comb begin
        q_push.valid      = s_valid & ~q_full & aresetn;
        q_push.entry.code = {h74e_pkg::code_nibble(s_data.data_byte[7:4]),
                             h74e_pkg::code_nibble(s_data.data_byte[3:0])};
        q_push.entry.last = s_data.last_byte;
    end

    assign unused_clk = aclk;

endmodule
`default_nettype wire

// ----- rtl/h74e_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h74e_queue
// Small FIFO that decouples the coder front end from the byte packer.
// ----------------------------------------------------------------------------
module h74e_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire h74e_pkg::q_xfer_t q_push,
    output logic                   q_full,
    output h74e_pkg::q_xfer_t      q_head,
    input  wire logic              q_pop
);

    h74e_pkg::q_entry_t                mem [h74e_pkg::QDepth];
    logic [h74e_pkg::QPtrW-1:0]        wr_ptr_reg;
    logic [h74e_pkg::QPtrW-1:0]        wr_ptr_next;
    logic [h74e_pkg::QPtrW-1:0]        rd_ptr_reg;
    logic [h74e_pkg::QPtrW-1:0]        rd_ptr_next;
    logic [h74e_pkg::QCntW-1:0]        count_reg;
    logic [h74e_pkg::QCntW-1:0]        count_next;
    logic                              do_push;
    logic                              do_pop;

    assign q_full  = (count_reg == h74e_pkg::QCntW'(h74e_pkg::QDepth));
    assign do_push = q_push.valid & ~q_full;
    assign do_pop  = q_pop & (count_reg != '0);

    // head entry
    always_comb begin
        q_head.valid = (count_reg != '0);
        q_head.entry = mem[rd_ptr_reg];
    end

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (!do_push && do_pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= q_push.entry;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/h74e_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h74e_back
// Byte packer: appends queued code words to a bit buffer, emits one byte per
// cycle MSB-first while not stalled, and a zero-padded flush byte at end of message.
// ----------------------------------------------------------------------------
module h74e_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire h74e_pkg::q_xfer_t q_head,
    output logic                   q_pop,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output h74e_pkg::out_t         m_data
);

    localparam logic [h74e_pkg::CntW-1:0] CntByte = h74e_pkg::CntW'(h74e_pkg::ByteW);
    localparam logic [h74e_pkg::CntW-1:0] CntCode = h74e_pkg::CntW'(h74e_pkg::CodeW);

    logic [h74e_pkg::BufW-1:0] buf_reg;
    logic [h74e_pkg::BufW-1:0] buf_next;
    logic [h74e_pkg::CntW-1:0] cnt_reg;
    logic [h74e_pkg::CntW-1:0] cnt_next;
    logic                      flush_reg;
    logic                      flush_next;
    logic                      m_valid_reg;
    logic                      m_valid_next;
    h74e_pkg::out_t            m_data_reg;
    h74e_pkg::out_t            m_data_next;

    logic                      can_out;
    logic                      emit_byte;
    logic                      emit_flush;
    logic [h74e_pkg::CntW-1:0] cnt_mid;
    logic                      flush_mid;
    logic                      load;
    logic [h74e_pkg::CntW-1:0] rshift;
    logic [h74e_pkg::CntW-1:0] lshift;
    logic [h74e_pkg::BufW-1:0] byte_win;
    logic [h74e_pkg::BufW-1:0] flush_win;

    // output slot free this cycle
    assign can_out = ~m_valid_reg | m_ready;

    // byte extraction: valid bits sit right-aligned in the buffer
    assign rshift    = cnt_reg - CntByte;
    assign lshift    = CntByte - cnt_reg;
    assign byte_win  = buf_reg >> rshift;
    assign flush_win = buf_reg << lshift;

    // emit, then refill from the queue once fewer than a byte remain
    always_comb begin
        emit_byte  = (cnt_reg >= CntByte) & can_out;
        emit_flush = (cnt_reg < CntByte) & flush_reg & can_out;

        cnt_mid   = cnt_reg;
        flush_mid = flush_reg;
        if (emit_byte) begin
            cnt_mid = cnt_reg - CntByte;
        end else if (emit_flush) begin
            cnt_mid   = '0;
            flush_mid = 1'b0;
        end

        load  = (cnt_mid < CntByte) & ~flush_mid & q_head.valid;
        q_pop = load;

        cnt_next   = cnt_mid;
        buf_next   = buf_reg;
        flush_next = flush_mid;
        if (load) begin
            cnt_next   = cnt_mid + CntCode;
            buf_next   = {buf_reg[h74e_pkg::LeftW-1:0], q_head.entry.code};
            flush_next = q_head.entry.last;
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit_byte) begin
            m_valid_next               = 1'b1;
            m_data_next.code_byte      = byte_win[h74e_pkg::ByteW-1:0];
            m_data_next.end_of_message = 1'b0;
        end else if (emit_flush) begin
            m_valid_next               = 1'b1;
            m_data_next.code_byte      = flush_win[h74e_pkg::ByteW-1:0];
            m_data_next.end_of_message = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg     <= cnt_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        buf_reg    <= buf_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
`default_nettype wire

// ----- rtl/hamming74_byte_stream_encoder.sv -----
`default_nettype none
// An accepted input transaction passes the queue storage, the bit buffer and
// the output register before its first byte shows on m_.
// Throughput: one output byte per cycle while m_ready is high and coded bits are
// pending, set by the byte packer; an item is 14 bits. The last item of a message
// also yields a flush byte. Reset (aresetn low, synchronous) empties the queue,
// clears pending bits and drops m_valid.
// ----------------------------------------------------------------------------
// hamming74_byte_stream_encoder
// Codes each byte as two Hamming(7,4) words and packs the bit stream into
// bytes, with a flush byte at end of message.
// ----------------------------------------------------------------------------
module hamming74_byte_stream_encoder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire h74e_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output h74e_pkg::out_t      m_data
);

    h74e_pkg::q_xfer_t q_push;
    h74e_pkg::q_xfer_t q_head;
    logic              q_full;
    logic              q_pop;

    // coder front end
    h74e_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push)
    );

    // decoupling queue
    h74e_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    // byte packer
    h74e_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
`default_nettype wire

// ----- rtl/h74e_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// h74e_checker
// Port-level checks for the encoder, bound to the top level.
// ----------------------------------------------------------------------------
module h74e_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_valid,
    input wire logic           s_ready,
    input wire h74e_pkg::in_t  s_data,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire h74e_pkg::out_t m_data
);

    logic [3:0] open_msgs_reg;
    logic [3:0] open_msgs_next;
    logic       last_in;
    logic       eom_out;

    assign last_in = s_valid & s_ready & s_data.last_byte;
    assign eom_out = m_valid & m_ready & m_data.end_of_message;

    // messages whose last byte went in but whose flush byte is not out yet
    always_comb begin
        open_msgs_next = open_msgs_reg;
        if (last_in && !eom_out) begin
            open_msgs_next = open_msgs_reg + 1'b1;
        end else if (!last_in && eom_out) begin
            open_msgs_next = open_msgs_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_msgs_reg <= '0;
        end else begin
            open_msgs_reg <= open_msgs_next;
        end
    end

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result transaction changed while stalled");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    // a flush byte only follows an accepted last byte
    a_eom_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.end_of_message |-> open_msgs_reg != 4'd0)
        else $error("end of message without a pending last byte");

endmodule

bind hamming74_byte_stream_encoder h74e_checker u_h74e_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
